### rtl/utad_pkg.sv
// shared types, constants and helpers for the unsigned to ascii digits block
// no dependencies; imported by every module of the block
package utad_pkg;

    localparam int DEF_VALUE_WIDTH = 64;
    localparam int VALUE_MAX_WIDTH = 64;
    localparam int RADIX_WIDTH     = 2;
    localparam int CHAR_WIDTH      = 7;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 7'd57;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 7'd102;

    typedef enum logic [RADIX_WIDTH-1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } t_radix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_EMIT
    } t_state;

    // one queued request, value already masked to the used width
    typedef struct packed {
        logic [VALUE_MAX_WIDTH-1:0] value;
        t_radix                     radix;
    } t_item;

    // front to back handshake
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_req;

    // decimal digits of the largest w-bit number, log10(2) ~ 0.30103
    function automatic int dec_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input logic [3:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CHAR_WIDTH'(d);
        end else begin
            c = CHAR_LOWER_A + CHAR_WIDTH'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

### rtl/utad_front.sv
// front end: accepts requests, masks the value, decodes the radix, queues them
// depends on utad_pkg
module utad_front #(
    parameter int VALUE_WIDTH = utad_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    output logic                                  o_full,
    input  logic [utad_pkg::VALUE_MAX_WIDTH-1:0]  i_value,
    input  logic [utad_pkg::RADIX_WIDTH-1:0]      i_radix,
    output utad_pkg::t_req                        o_req,
    input  logic                                  i_take
);
    import utad_pkg::*;

    logic [1:0] r_count, n_count;
    logic       r_wp, r_rp;
    t_item      r_mem [2];
    t_item      w_item;
    logic       w_wr, w_rd;

    assign w_item.value = VALUE_MAX_WIDTH'(i_value[VALUE_WIDTH-1:0]);
    assign w_item.radix = t_radix'(i_radix);

    assign o_full = (r_count == 2'd2);
    assign w_wr   = i_push && !o_full;
    assign w_rd   = i_take && (r_count != 2'd0);

    assign o_req.valid = (r_count != 2'd0);
    assign o_req.item  = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule

### rtl/utad_back.sv
// back end: double-dabble for decimal, msb-first digit scan, output register
// depends on utad_pkg
module utad_back #(
    parameter int VALUE_WIDTH = utad_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  utad_pkg::t_req                    i_req,
    output logic                              o_take,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [utad_pkg::CHAR_WIDTH-1:0]   o_digit_char,
    output logic                              o_last_digit
);
    import utad_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int DEC_N  = dec_digits(W);
    localparam int HEX_N  = (W + 3) / 4;
    localparam int OCT_N  = (W + 2) / 3;
    localparam int BW     = 4 * DEC_N;
    localparam int SW     = max_int(max_int(BW, 4 * HEX_N), 3 * OCT_N);
    localparam int CW     = $clog2(W + 1);

    t_state             r_state, n_state;
    t_radix             r_radix, n_radix;
    logic [SW-1:0]      r_sh, n_sh;
    logic [BW-1:0]      r_bcd, n_bcd;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_started, n_started;
    logic               r_ov;
    logic [CHAR_WIDTH-1:0] r_char;
    logic               r_last;

    logic [3:0]         w_digit;
    logic               w_last_pos, w_skip, w_room, w_step, w_emit, w_popped;
    logic [BW-1:0]      w_adj;
    logic [W-1:0]       w_val;

    assign w_popped   = i_pop && r_ov;
    assign w_room     = !r_ov || w_popped;
    assign w_last_pos = (r_cnt == CW'(1));
    assign w_val      = i_req.item.value[W-1:0];

    // top digit of the scan register
    always_comb begin
        case (r_radix)
            RADIX_HEX: w_digit = r_sh[SW-1 -: 4];
            RADIX_OCT: w_digit = {1'b0, r_sh[SW-1 -: 3]};
            RADIX_BIN: w_digit = {3'b000, r_sh[SW-1]};
            default:   w_digit = r_sh[SW-1 -: 4];
        endcase
    end

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_N; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                         : r_bcd[4*i +: 4];
        end
    end

    // control decode
    always_comb begin
        o_take = 1'b0;
        w_skip = 1'b0;
        w_step = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_take = i_req.valid;
            end
            ST_DABBLE: begin
            end
            ST_EMIT: begin
                w_skip = (w_digit == 4'd0) && !r_started && !w_last_pos;
                w_step = w_skip || w_room;
                w_emit = w_step && !w_skip;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.item.radix == RADIX_DEC) ? ST_DABBLE : ST_EMIT;
                end
            end
            ST_DABBLE: begin
                if (r_cnt == CW'(0)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_step && w_last_pos) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_radix   = r_radix;
        n_sh      = r_sh;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_started = r_started;
        unique case (r_state)
            ST_IDLE: begin
                n_radix   = i_req.item.radix;
                n_started = 1'b0;
                n_bcd     = '0;
                unique case (i_req.item.radix)
                    RADIX_HEX: begin
                        n_sh  = SW'(w_val) << (SW - 4 * HEX_N);
                        n_cnt = CW'(HEX_N);
                    end
                    RADIX_OCT: begin
                        n_sh  = SW'(w_val) << (SW - 3 * OCT_N);
                        n_cnt = CW'(OCT_N);
                    end
                    RADIX_BIN: begin
                        n_sh  = SW'(w_val) << (SW - W);
                        n_cnt = CW'(W);
                    end
                    default: begin
                        n_sh  = SW'(w_val) << (SW - W);
                        n_cnt = CW'(W);
                    end
                endcase
            end
            ST_DABBLE: begin
                if (r_cnt == CW'(0)) begin
                    n_sh  = SW'(r_bcd) << (SW - BW);
                    n_cnt = CW'(DEC_N);
                end else begin
                    n_bcd = {w_adj[BW-2:0], r_sh[SW-1]};
                    n_sh  = r_sh << 1;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_EMIT: begin
                if (w_step) begin
                    n_cnt = r_cnt - CW'(1);
                    if (w_emit) begin
                        n_started = 1'b1;
                    end
                    case (r_radix)
                        RADIX_OCT: n_sh = r_sh << 3;
                        RADIX_BIN: n_sh = r_sh << 1;
                        default:   n_sh = r_sh << 4;
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ov      <= 1'b0;
            r_cnt     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_started <= n_started;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (w_popped) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        r_sh    <= n_sh;
        r_bcd   <= n_bcd;
        if (w_emit) begin
            r_char <= digit_to_char(w_digit);
            r_last <= w_last_pos;
        end
    end

    assign o_empty      = !r_ov;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

endmodule

### rtl/unsigned_to_ascii_digits.sv
// top level of the unsigned to ascii digits converter
// depends on utad_pkg, utad_front and utad_back
//
// Each request carries a value (its low VALUE_WIDTH bits are used, higher bits
// are ignored) and a radix code: 0 decimal, 1 hexadecimal, 2 octal, 3 binary.
// The block returns the value's ASCII digits one result at a time, most
// significant first, no leading zeros, lower-case 'a'..'f' for hex, a single
// '0' for a zero value, with last_digit set on the final digit. Requests enter
// through push/full into a two-entry queue and results leave through
// empty/pop from a one-entry output register, so both sides may stall freely.
// Conversion per request: the digit scan walks one digit position per cycle
// while the output register has room (leading zeros are skipped at the same
// pace, even while it is full); decimal first loads the value, runs the
// double-dabble loop, which takes one value bit per cycle, and then moves the
// BCD digits to the digit scan. A stalled consumer holds the digit scan. There
// is no clearing pass after reset.
module unsigned_to_ascii_digits #(
    parameter int VALUE_WIDTH = utad_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request side
    input  logic                                  push,
    output logic                                  full,
    input  logic [utad_pkg::VALUE_MAX_WIDTH-1:0]  i_value,
    input  logic [utad_pkg::RADIX_WIDTH-1:0]      i_radix,
    // result side
    output logic                                  empty,
    input  logic                                  pop,
    output logic [utad_pkg::CHAR_WIDTH-1:0]       o_digit_char,
    output logic                                  o_last_digit
);
    import utad_pkg::*;

    // queued request toward the converter, and its dequeue strobe
    t_req w_req;
    logic w_take;

    // front: mask, decode and queue incoming requests
    utad_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_value (i_value),
        .i_radix (i_radix),
        .o_req   (w_req),
        .i_take  (w_take)
    );

    // back: convert one request at a time and hand out digits
    utad_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .o_take       (w_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

### rtl/utad_checker.sv
// port-level checks for unsigned_to_ascii_digits, attached by bind
// depends on utad_pkg
module utad_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  push,
    input logic                                  full,
    input logic [utad_pkg::VALUE_MAX_WIDTH-1:0]  i_value,
    input logic [utad_pkg::RADIX_WIDTH-1:0]      i_radix,
    input logic                                  empty,
    input logic                                  pop,
    input logic [utad_pkg::CHAR_WIDTH-1:0]       o_digit_char,
    input logic                                  o_last_digit
);
    import utad_pkg::*;

    // set while the next result starts a new number
    logic r_at_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else if (pop && !empty) begin
            r_at_start <= o_last_digit;
        end
    end

    // reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_digit_char) && $stable(o_last_digit)))
        else $error("waiting result changed");

    // only digit characters leave the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_digit_char >= CHAR_ZERO && o_digit_char <= CHAR_NINE) ||
                    (o_digit_char >= CHAR_LOWER_A && o_digit_char <= CHAR_LOWER_F)))
        else $error("result is not a digit character");

    // a number never starts with a zero unless it is the lone zero
    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_at_start && o_digit_char == CHAR_ZERO) |-> o_last_digit)
        else $error("leading zero digit");

endmodule

bind unsigned_to_ascii_digits utad_checker u_utad_checker (.*);
